[rtl/core/plcm_pkg.sv]
// Shared constants and types for the colormap lookup unit.
package plcm_pkg;

    localparam int MAX_STOPS     = 64;
    localparam int POS_FRAC_BITS = 16;
    localparam int IDX_W         = 6;
    localparam int CNT_W         = 7;
    localparam int POS_W         = POS_FRAC_BITS + 1;
    localparam int SPOS_W        = POS_FRAC_BITS + 2;
    localparam int CH_W          = 8;
    localparam logic [POS_W-1:0] POS_ONE = POS_W'(1) << POS_FRAC_BITS;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [CH_W-1:0]  red;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  blue;
    } t_stop;

    // Search token that walks the cell row.
    typedef struct packed {
        logic             vld;
        logic [POS_W-1:0] t;
        logic             found;
        logic             done;
        t_stop            lo;
        t_stop            hi;
    } t_tok;

endpackage

[rtl/core/plcm_cell.sv]
// One stop cell: holds a stop and refines a passing search token.
module plcm_cell (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_wr,
    input  plcm_pkg::t_stop                  i_stop,
    input  logic                             i_active,
    input  logic                             i_first,
    input  logic                             i_last,
    input  plcm_pkg::t_tok                   i_tok,
    output plcm_pkg::t_tok                   o_tok
);
    plcm_pkg::t_stop r_stop;
    plcm_pkg::t_tok  r_tok;
    plcm_pkg::t_tok  n_tok;

    always_comb begin
        n_tok = i_tok;
        if (i_tok.vld && !i_tok.done && i_active) begin
            if (i_first) begin
                n_tok.lo = r_stop;
                n_tok.hi = r_stop;
                if (i_tok.t <= r_stop.pos) n_tok.done = 1'b1;
            end else if (i_last && i_tok.t >= r_stop.pos) begin
                // at or above the last stop: give its color
                n_tok.lo   = r_stop;
                n_tok.hi   = r_stop;
                n_tok.done = 1'b1;
            end else if (!i_tok.found) begin
                if (i_last || i_tok.t <= r_stop.pos) begin
                    n_tok.hi    = r_stop;
                    n_tok.found = 1'b1;
                end else begin
                    n_tok.lo = r_stop;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) r_stop <= i_stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_tok <= '0;
        else r_tok <= n_tok;
    end

    assign o_tok = r_tok;
endmodule

[rtl/core/plcm_lerp.sv]
// Interpolation back end: bit-serial staged lerp per channel.
module plcm_lerp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  plcm_pkg::t_tok  i_tok,
    output logic            o_vld,
    output logic [23:0]     o_rgb,
    input  logic            i_hold
);
    localparam int DW  = plcm_pkg::POS_W;
    localparam int NW  = DW + plcm_pkg::CH_W + 2;
    typedef enum logic [1:0] {S_IDLE, S_DIV, S_DONE} t_state;

    t_state            r_state;
    logic [DW-1:0]     r_den;
    logic [NW-1:0]     r_rem [3];
    logic              r_neg [3];
    logic [plcm_pkg::CH_W-1:0] r_c0 [3];
    logic [NW-1:0]     r_q [3];
    logic [4:0]        r_cnt;
    logic              r_plain;
    logic [23:0]       r_rgb;

    logic [plcm_pkg::CH_W-1:0] c0 [3];
    logic [plcm_pkg::CH_W-1:0] c1 [3];
    logic [DW-1:0]             dt;
    logic [DW-1:0]             den;
    logic [NW-1:0]             mag [3];
    logic [NW-1:0]             twice_num [3];

    assign c0[0] = i_tok.lo.red;   assign c1[0] = i_tok.hi.red;
    assign c0[1] = i_tok.lo.green; assign c1[1] = i_tok.hi.green;
    assign c0[2] = i_tok.lo.blue;  assign c1[2] = i_tok.hi.blue;
    assign dt  = i_tok.t - i_tok.lo.pos;
    assign den = i_tok.hi.pos - i_tok.lo.pos;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (c1[k] < c0[k]) mag[k] = NW'(c0[k] - c1[k]);
            else mag[k] = NW'(c1[k] - c0[k]);
            twice_num[k] = NW'(mag[k] * NW'(dt)) << 1;
        end
    end

    // restoring divide of |2*num|+-den by 2*den, one bit a cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_tok.vld) begin
                        r_plain <= (i_tok.hi.pos <= i_tok.lo.pos)
                                   || (i_tok.t <= i_tok.lo.pos);
                        r_den   <= den;
                        for (int k = 0; k < 3; k++) begin
                            r_c0[k]  <= c0[k];
                            r_neg[k] <= c1[k] < c0[k];
                            r_q[k]   <= '0;
                            // |num|*2 - den, floored at zero, or |num|*2 + den
                            if (c1[k] < c0[k])
                                r_rem[k] <= (twice_num[k] > NW'(den))
                                            ? twice_num[k] - NW'(den) : '0;
                            else
                                r_rem[k] <= twice_num[k] + NW'(den);
                        end
                        r_cnt   <= 5'(plcm_pkg::CH_W + 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    for (int k = 0; k < 3; k++) begin
                        if (r_rem[k] >= (NW'({r_den, 1'b0}) << r_cnt)) begin
                            r_rem[k] <= r_rem[k] - (NW'({r_den, 1'b0}) << r_cnt);
                            r_q[k]   <= r_q[k] | (NW'(1) << r_cnt);
                        end
                    end
                    if (r_cnt == '0) r_state <= S_DONE;
                    else r_cnt <= r_cnt - 5'd1;
                end
                S_DONE: begin
                    if (!i_hold) begin
                        for (int k = 0; k < 3; k++) begin
                            if (r_plain) r_rgb[8*(2-k) +: 8] <= r_c0[k];
                            // negative slope: floor(-(a-d)/2d) = -ceil((a-d)/2d)
                            else if (r_neg[k])
                                r_rgb[8*(2-k) +: 8] <= r_c0[k] - 8'(r_q[k])
                                    - 8'(r_rem[k] != '0);
                            else r_rgb[8*(2-k) +: 8] <= r_c0[k] + 8'(r_q[k]);
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    logic r_vld;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= 1'b0;
        else if (r_state == S_DONE && !i_hold) r_vld <= 1'b1;
        else if (!i_hold) r_vld <= 1'b0;
    end

    assign o_vld = r_vld;
    assign o_rgb = r_rgb;
endmodule

[rtl/core/piecewise_linear_colormap_lookup_unit.sv]
// Top level of the piecewise-linear colormap lookup unit.
// Usage: s_axis words carry stop writes (tuser = 0) and samples (tuser = 1).
// A stop write stores one stop in its cell and returns nothing. A sample
// clamps its position to 0..1.0, walks the row of 64 stop cells (one cell
// a cycle), is captured by a shared bit-serial divider that interpolates
// the three channels, and the color lands in an output register on m_axis.
// One sample is in flight at a time: no new word is taken until its result
// has been accepted on m_axis. The user must write the stop_count register
// on the cfg channel only while idle; the block does not enforce this.
// Reset clears control state and sets stop_count to 2; the stop table is
// undefined until written. When m_axis_tready is low the result holds and
// no new sample is taken until it drains.
module piecewise_linear_colormap_lookup_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: stop_index[5:0], stop_pos[22:6], red[30:23], green[38:31],
    //        blue[46:39], sample_pos[64:47], zero[71:65]
    input  logic [71:0] s_axis_tdata,
    // tuser: req_type
    input  logic        s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [23:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [6:0]  i_cfg_data
);
    localparam int N = plcm_pkg::MAX_STOPS;

    logic [plcm_pkg::CNT_W-1:0] r_count;
    logic [plcm_pkg::IDX_W:0]   act_n;
    logic                       r_busy;
    logic                       acc;
    plcm_pkg::t_tok             tok [N+1];
    plcm_pkg::t_stop            wstop;
    logic [16:0]                spos;
    logic signed [17:0]         samp;
    logic [plcm_pkg::POS_W-1:0] t_cl;
    logic                       lerp_vld;
    logic [23:0]                lerp_rgb;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_count <= 7'd2;
        else if (i_cfg_valid) r_count <= i_cfg_data;
    end
    assign act_n = (r_count < 7'd2) ? 7'd2 : (r_count > 7'(N)) ? 7'(N) : r_count;

    assign s_axis_tready = !r_busy;
    assign acc = s_axis_tvalid && s_axis_tready;

    assign spos = s_axis_tdata[22:6];
    assign wstop.pos   = (spos > plcm_pkg::POS_ONE) ? plcm_pkg::POS_ONE : spos;
    assign wstop.red   = s_axis_tdata[30:23];
    assign wstop.green = s_axis_tdata[38:31];
    assign wstop.blue  = s_axis_tdata[46:39];
    assign samp = s_axis_tdata[64:47];
    assign t_cl = samp[17] ? '0 :
                  (samp > 18'sd65536) ? plcm_pkg::POS_ONE : samp[16:0];

    always_comb begin
        tok[0]       = '0;
        tok[0].vld   = acc && s_axis_tuser == plcm_pkg::REQ_SAMPLE;
        tok[0].t     = t_cl;
    end

    for (genvar g = 0; g < N; g++) begin : g_cell
        plcm_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_wr     (acc && s_axis_tuser == plcm_pkg::REQ_WRITE
                       && s_axis_tdata[5:0] == 6'(g)),
            .i_stop   (wstop),
            .i_active (7'(g) < act_n),
            .i_first  (g == 0),
            .i_last   (7'(g) == act_n - 7'd1),
            .i_tok    (tok[g]),
            .o_tok    (tok[g+1])
        );
    end

    plcm_lerp u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok[N]),
        .o_vld   (lerp_vld),
        .o_rgb   (lerp_rgb),
        .i_hold  (m_axis_tvalid && !m_axis_tready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_busy <= 1'b0;
        else if (acc && s_axis_tuser == plcm_pkg::REQ_SAMPLE) r_busy <= 1'b1;
        else if (m_axis_tvalid && m_axis_tready) r_busy <= 1'b0;
    end

    assign m_axis_tvalid = lerp_vld;
    assign m_axis_tdata  = {lerp_rgb[7:0], lerp_rgb[15:8], lerp_rgb[23:16]};
endmodule

[rtl/core/plcm_checker.sv]
// Port-level checker for the colormap lookup unit.
module plcm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped under stall");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
        else $error("second sample taken while busy");
    a_nowr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> ##1 !m_axis_tvalid || $past(m_axis_tvalid, 2))
        else $error("write produced a result");
endmodule

bind piecewise_linear_colormap_lookup_unit plcm_checker u_plcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[tb/testbench.sv]
// Self-checking testbench for the piecewise-linear colormap lookup unit.
`timescale 1ns / 100ps

module testbench;

    typedef struct {
        logic             kind;
        logic [5:0]       idx;
        logic [16:0]      pos;
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [17:0]      spos;
    } t_req;

    typedef struct {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [6:0]  i_cfg_data = '0;

    piecewise_linear_colormap_lookup_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // color ramp mirror
    longint ramp_pos [plcm_pkg::MAX_STOPS];
    longint ramp_ch [plcm_pkg::MAX_STOPS][3];
    logic [6:0] ramp_count = 7'd2;

    t_req   pending_q[$];
    t_rgb   color_q[$];
    int     errors = 0;
    int     n_samples = 0;
    int     n_writes = 0;
    int     n_cfg = 0;
    int     gap_max = 12;
    int     stall_max = 12;
    logic [6:0] counts [10] = '{7'd64, 7'd2, 7'd0, 7'd1, 7'd127, 7'd65, 7'd5, 7'd33, 7'd3,
                                7'd64};

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    task automatic queue_item(input t_req r);
        pending_q.insert(pending_q.size(), r);
    endtask

    function automatic longint lerp(longint c0, longint c1, longint t, longint t0, longint t1);
        longint den, num, a, b;
        if (t1 <= t0) return c0;
        den = t1 - t0;
        num = (c1 - c0) * (t - t0);
        a = 2 * num + den;
        b = 2 * den;
        if (a >= 0) return c0 + a / b;
        return c0 - ((-a + b - 1) / b);
    endfunction

    task automatic apply_req(input t_req r);
        longint t, v;
        int n, i, sel, k;
        t_rgb c;
        if (r.kind == plcm_pkg::REQ_WRITE) begin
            ramp_pos[r.idx] = (r.pos > 17'd65536) ? 65536 : longint'(r.pos);
            ramp_ch[r.idx][0] = longint'(r.red);
            ramp_ch[r.idx][1] = longint'(r.green);
            ramp_ch[r.idx][2] = longint'(r.blue);
            n_writes++;
            return;
        end
        t = longint'($signed(r.spos));
        if (t < 0) t = 0;
        if (t > 65536) t = 65536;
        n = int'(ramp_count);
        if (n < 2) n = 2;
        if (n > plcm_pkg::MAX_STOPS) n = plcm_pkg::MAX_STOPS;
        sel = -1;
        if (t <= ramp_pos[0]) sel = 0;
        else if (t >= ramp_pos[n-1]) sel = n - 1;
        else begin
            for (i = 1; i < n; i++) if (t <= ramp_pos[i]) break;
            if (i >= n) sel = n - 1;
        end
        for (k = 0; k < 3; k++) begin
            if (sel >= 0) v = ramp_ch[sel][k];
            else v = lerp(ramp_ch[i-1][k], ramp_ch[i][k], t, ramp_pos[i-1], ramp_pos[i]);
            if (v < 0) v = 0;
            if (v > 255) v = 255;
            if (k == 0) c.red = v[7:0];
            else if (k == 1) c.green = v[7:0];
            else c.blue = v[7:0];
        end
        color_q.insert(color_q.size(), c);
        n_samples++;
    endtask

    // driver
    t_req cur;
    bit   holding = 0;
    int   gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_req(cur);
                holding = 0;
                gap = $urandom_range(0, gap_max);
            end
            if (!holding) begin
                if (gap > 0) gap--;
                else if (pending_q.size() > 0) begin
                    cur = pending_q.pop_front();
                    holding = 1;
                end
            end
            s_axis_tvalid <= holding;
            s_axis_tuser <= cur.kind;
            if (cur.kind == plcm_pkg::REQ_WRITE)
                s_axis_tdata <= {25'b0, cur.blue, cur.green, cur.red, cur.pos, cur.idx};
            else
                s_axis_tdata <= {7'b0, cur.spos, 47'b0};
        end
    end

    // monitor
    int stall = 0;
    always @(posedge i_clk) begin
        t_rgb w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (color_q.size() == 0) begin
                    report("unexpected word", m_axis_tdata, 0);
                end else begin
                    w = color_q.pop_front();
                    if (m_axis_tdata[7:0] !== w.red) report("red", m_axis_tdata[7:0], w.red);
                    if (m_axis_tdata[15:8] !== w.green)
                        report("green", m_axis_tdata[15:8], w.green);
                    if (m_axis_tdata[23:16] !== w.blue)
                        report("blue", m_axis_tdata[23:16], w.blue);
                end
                stall = $urandom_range(0, stall_max);
            end
            if (stall > 0) begin
                stall--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic t_req mk_write(int idx, int pos, int r, int g, int b);
        t_req q;
        q.kind = plcm_pkg::REQ_WRITE; q.idx = 6'(idx); q.pos = 17'(pos);
        q.red = 8'(r); q.green = 8'(g); q.blue = 8'(b); q.spos = '0;
        return q;
    endfunction

    function automatic t_req mk_sample(int spos);
        t_req q;
        q.kind = plcm_pkg::REQ_SAMPLE; q.idx = '0; q.pos = '0;
        q.red = '0; q.green = '0; q.blue = '0; q.spos = 18'(spos);
        return q;
    endfunction

    function automatic int rand_spos();
        case ($urandom_range(0, 9))
            0: return -int'($urandom_range(0, 131072));
            1: return $urandom_range(65536, 131071);
            default: return int'($urandom_range(0, 68000)) - 1500;
        endcase
    endfunction

    // load an ascending ramp over all entries, with occasional shared positions
    task automatic load_ramp();
        int p [plcm_pkg::MAX_STOPS];
        int i;
        for (i = 0; i < plcm_pkg::MAX_STOPS; i++) begin
            if (i > 0 && $urandom_range(0, 7) == 0) p[i] = p[i-1];
            else p[i] = $urandom_range(0, 70000);
        end
        p.sort();
        if ($urandom_range(0, 1)) p[0] = 0;
        if ($urandom_range(0, 1)) p[plcm_pkg::MAX_STOPS-1] = $urandom_range(65536, 131071);
        for (i = 0; i < plcm_pkg::MAX_STOPS; i++)
            queue_item(mk_write(i, p[i], $urandom_range(0, 255),
                                $urandom_range(0, 255), $urandom_range(0, 255)));
    endtask

    task automatic wait_idle();
        while (pending_q.size() > 0 || holding || color_q.size() > 0) @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [6:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        ramp_count = v;
        n_cfg++;
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int ph, j, pos;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        load_ramp();
        // directed: extremes, saturation, shared stops, rounding ties
        queue_item(mk_write(0, 0, 0, 255, 0));
        queue_item(mk_write(1, 131071, 255, 0, 1));
        queue_item(mk_sample(-131072));
        queue_item(mk_sample(131071));
        queue_item(mk_sample(0));
        queue_item(mk_sample(65536));
        queue_item(mk_sample(32768));
        queue_item(mk_sample(128));
        queue_item(mk_sample(65535));
        queue_item(mk_write(1, 2, 1, 0, 255));
        queue_item(mk_sample(1));
        queue_item(mk_write(1, 0, 9, 9, 9));
        queue_item(mk_sample(0));
        queue_item(mk_sample(1));
        queue_item(mk_write(63, 65536, 255, 255, 255));
        wait_idle();
        for (ph = 0; ph < 10; ph++) begin
            write_count(counts[ph]);
            gap_max = (ph % 4 == 1) ? 0 : 12;
            stall_max = (ph % 4 == 2) ? 0 : 12;
            load_ramp();
            if (ph == 9) queue_item(mk_write(5, 40000, 1, 2, 3));
            for (j = 0; j < 55; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    pos = $urandom_range(0, 131071);
                    queue_item(mk_write($urandom_range(0, 63), pos,
                        $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255)));
                end else begin
                    queue_item(mk_sample(rand_spos()));
                end
            end
            wait_idle();
        end
        $display("covered %0d samples, %0d stop writes, %0d stop_count writes",
                 n_samples, n_writes, n_cfg);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #30000000;
        $display("timeout");
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
